### design/bsr_pkg.sv
`default_nettype none

package bsr_pkg;

    // field widths
    localparam int PCT_W    = 7;
    localparam int MIN_W    = 11;
    localparam int HOUR_W   = 5;
    localparam int MOH_W    = 6;
    localparam int REQ_W    = 8;
    localparam int DUTY_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 11;

    // input beat layout
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    // percent and schedule constants
    localparam logic [PCT_W-1:0]  MAX_PCT       = 7'd100;
    localparam logic [MIN_W-1:0]  MIN_PER_HOUR  = 11'd60;
    localparam logic [PCT_W-1:0]  STEP_TH_BIG   = 7'd20;
    localparam logic [PCT_W-1:0]  STEP_TH_MID   = 7'd10;
    localparam logic [PCT_W-1:0]  STEP_TH_SMALL = 7'd3;
    localparam logic [2:0]        STEP_BIG      = 3'd5;
    localparam logic [2:0]        STEP_MID      = 3'd3;
    localparam logic [2:0]        STEP_SMALL    = 3'd2;
    localparam logic [2:0]        STEP_MIN      = 3'd1;

    // duty = pct*255/100 as pct * (255*ceil(2^19/100)) >> 19, exact for pct <= 100
    localparam int               DUTY_SHIFT = 19;
    localparam int               DUTY_MUL_W = 21;
    localparam logic [DUTY_MUL_W-1:0] DUTY_MUL = 21'd1336965;

    // shared divider
    localparam int DIV_N_W   = 18;
    localparam int DIV_D_W   = 11;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    // reset values of the registers
    localparam logic [PCT_W-1:0] RST_DIM        = 7'd0;
    localparam logic [PCT_W-1:0] RST_BRIGHT     = 7'd100;
    localparam logic [MIN_W-1:0] RST_DAWN_START = 11'd360;
    localparam logic [MIN_W-1:0] RST_DAWN_END   = 11'd420;
    localparam logic [MIN_W-1:0] RST_DUSK_START = 11'd1200;
    localparam logic [MIN_W-1:0] RST_DUSK_END   = 11'd1260;
    localparam logic [PCT_W-1:0] RST_LEVEL      = 7'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIM        = 3'd0,
        CFG_BRIGHT     = 3'd1,
        CFG_DAWN_START = 3'd2,
        CFG_DAWN_END   = 3'd3,
        CFG_DUSK_START = 3'd4,
        CFG_DUSK_END   = 3'd5,
        CFG_INVERT     = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        RG_FLAT = 2'd0,
        RG_UP   = 2'd1,
        RG_DOWN = 2'd2
    } region_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SELECT,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_TARGET,
        ST_STEP,
        ST_APPLY,
        ST_DUTY,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic select;
        logic div_start;
        logic target;
        logic step;
        logic apply;
        logic duty;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_busy;
    } dp_status_t;

endpackage

`default_nettype wire

### design/backlight_schedule_ramp.sv
// per input beat: an invalid tick goes to duty and output load, a manual set through apply
//   first, a tick outside a ramp through region select, target and step first; a tick
//   inside a dawn or dusk ramp also runs the 18-step restoring divider that scales the
//   ramp span, before target; a new beat is taken only after the result is loaded out
// reset: synchronous active-low aresetn restores all registers to their defaults and the
//   level to 100 percent; no clearing pass, inputs are taken on the first cycle after reset
`default_nettype none

module backlight_schedule_ramp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input channel
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [4:0] hour_of_day, [10:5] minute_of_hour, [18:11] requested_level, [23:19] zero
    input  wire logic [bsr_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] op, [1] time_valid
    input  wire logic [bsr_pkg::S_TUSER_W-1:0] s_tuser,
    // result channel
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [6:0] level, [14:7] duty, [15] duty_written
    output logic [bsr_pkg::M_TDATA_W-1:0]      m_tdata,
    // register write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bsr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bsr_pkg::CFG_DAT_W-1:0] cfg_data
);
    import bsr_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    // controller: sequences one beat at a time through region select,
    // ramp divide, target, step or manual apply, duty and output load
    bsr_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_op         (s_tuser[0]),
        .s_time_valid (s_tuser[1]),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .cmd          (cmd),
        .sts          (sts)
    );

    // datapath: registers, level state, ramp divider, duty scaling and
    // the output register that holds a result while the next beat is taken
    bsr_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire

### design/bsr_div.sv
`default_nettype none

module bsr_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [bsr_pkg::DIV_N_W-1:0] dividend,
    input  wire logic [bsr_pkg::DIV_D_W-1:0] divisor,
    output logic                             busy,
    output logic [bsr_pkg::DIV_N_W-1:0]      quotient
);
    import bsr_pkg::*;

    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_N_W-1:0]   quo_reg, quo_next;
    logic [DIV_D_W-1:0]   den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_D_W:0]     shifted;
    logic                 ge;

    // restoring division, one quotient bit per cycle
    always_comb begin
        shifted  = {rem_reg, quo_reg[DIV_N_W-1]};
        ge       = shifted >= {1'b0, den_reg};
        rem_next = ge ? DIV_D_W'(shifted - {1'b0, den_reg}) : shifted[DIV_D_W-1:0];
        quo_next = {quo_reg[DIV_N_W-2:0], ge};
        cnt_next = cnt_reg - DIV_CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= DIV_CNT_W'(DIV_N_W);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end else if (cnt_reg != '0) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = cnt_reg != '0;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### design/bsr_datapath.sv
`default_nettype none

module bsr_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire bsr_pkg::ctrl_cmd_t            cmd,
    output bsr_pkg::dp_status_t                sts,
    input  wire logic [bsr_pkg::S_TDATA_W-1:0] s_tdata,
    output logic [bsr_pkg::M_TDATA_W-1:0]      m_tdata,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bsr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bsr_pkg::CFG_DAT_W-1:0] cfg_data
);
    import bsr_pkg::*;

    // configuration
    logic [PCT_W-1:0] dim_reg, bright_reg;
    logic [MIN_W-1:0] dawn_start_reg, dawn_end_reg, dusk_start_reg, dusk_end_reg;
    logic             invert_reg;

    // item state
    logic [PCT_W-1:0] level_reg;
    logic             written_reg;
    logic [MIN_W-1:0] t_reg;
    logic [REQ_W-1:0] req_reg;
    region_t          region_reg, region_next;
    logic [MIN_W-1:0] off_reg, off_next, len_reg, len_next;
    logic [PCT_W-1:0] span_abs_reg, span_abs_next, flat_reg, flat_next;
    logic             span_neg_reg;
    logic [PCT_W-1:0] tgt_reg;
    logic [DUTY_W-1:0] duty_reg;

    logic [PCT_W-1:0]  out_level_reg;
    logic [DUTY_W-1:0] out_duty_reg;
    logic              out_written_reg;

    // input fields
    logic [HOUR_W-1:0] in_hour;
    logic [MOH_W-1:0]  in_minute;
    logic [REQ_W-1:0]  in_req;
    logic [MIN_W-1:0]  t_next;

    logic             in_dawn, in_day, in_dusk;
    logic signed [PCT_W:0] span;

    logic                  div_busy;
    logic [DIV_N_W-1:0]    div_quo;
    logic [DIV_N_W-1:0]    div_num;
    logic signed [PCT_W+1:0] sq, tgt9;
    logic [PCT_W-1:0]      base;

    logic [PCT_W-1:0]      delta;
    logic [2:0]            step_sz;
    logic [PCT_W:0]        next_lvl;
    logic [PCT_W-1:0]      next_clamped, req_clamped;
    logic [PCT_W+DUTY_MUL_W-1:0] duty_prod;
    logic [DUTY_W-1:0]     duty_raw;

    assign in_hour   = s_tdata[HOUR_W-1:0];
    assign in_minute = s_tdata[HOUR_W +: MOH_W];
    assign in_req    = s_tdata[HOUR_W+MOH_W +: REQ_W];
    assign t_next    = MIN_W'(in_hour) * MIN_PER_HOUR + MIN_W'(in_minute);

    // configuration writes, unknown index ignored
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_reg        <= RST_DIM;
            bright_reg     <= RST_BRIGHT;
            dawn_start_reg <= RST_DAWN_START;
            dawn_end_reg   <= RST_DAWN_END;
            dusk_start_reg <= RST_DUSK_START;
            dusk_end_reg   <= RST_DUSK_END;
            invert_reg     <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_DIM:        dim_reg        <= cfg_data[PCT_W-1:0];
                CFG_BRIGHT:     bright_reg     <= cfg_data[PCT_W-1:0];
                CFG_DAWN_START: dawn_start_reg <= cfg_data;
                CFG_DAWN_END:   dawn_end_reg   <= cfg_data;
                CFG_DUSK_START: dusk_start_reg <= cfg_data;
                CFG_DUSK_END:   dusk_end_reg   <= cfg_data;
                CFG_INVERT:     invert_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // schedule region for the captured minute
    always_comb begin
        in_dawn = (t_reg >= dawn_start_reg) && (t_reg < dawn_end_reg)
                  && (dawn_end_reg > dawn_start_reg);
        in_day  = (t_reg >= dawn_end_reg) && (t_reg < dusk_start_reg);
        in_dusk = (t_reg >= dusk_start_reg) && (t_reg < dusk_end_reg)
                  && (dusk_end_reg > dusk_start_reg);
        span    = $signed({1'b0, bright_reg}) - $signed({1'b0, dim_reg});
        span_abs_next = span[PCT_W] ? PCT_W'(-span) : span[PCT_W-1:0];
        region_next = RG_FLAT;
        off_next    = t_reg - dawn_start_reg;
        len_next    = dawn_end_reg - dawn_start_reg;
        flat_next   = dim_reg;
        if (in_dawn) begin
            region_next = RG_UP;
        end else if (in_day) begin
            flat_next = bright_reg;
        end else if (in_dusk) begin
            region_next = RG_DOWN;
            off_next    = t_reg - dusk_start_reg;
            len_next    = dusk_end_reg - dusk_start_reg;
        end
    end

    assign sts.need_div = in_dawn || (!in_day && in_dusk);
    assign sts.div_busy = div_busy;

    assign div_num = DIV_N_W'(span_abs_reg) * DIV_N_W'(off_reg);

    bsr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_num),
        .divisor  (len_reg),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // ramp target from the truncated quotient
    always_comb begin
        sq   = span_neg_reg ? -$signed({2'b00, div_quo[PCT_W-1:0]})
                            :  $signed({2'b00, div_quo[PCT_W-1:0]});
        base = (region_reg == RG_UP) ? dim_reg : bright_reg;
        tgt9 = (region_reg == RG_UP) ? $signed({2'b00, base}) + sq
                                     : $signed({2'b00, base}) - sq;
    end

    // adaptive step toward the target
    always_comb begin
        delta = (level_reg > tgt_reg) ? level_reg - tgt_reg : tgt_reg - level_reg;
        if (delta >= STEP_TH_BIG) begin
            step_sz = STEP_BIG;
        end else if (delta >= STEP_TH_MID) begin
            step_sz = STEP_MID;
        end else if (delta >= STEP_TH_SMALL) begin
            step_sz = STEP_SMALL;
        end else begin
            step_sz = STEP_MIN;
        end
        if (PCT_W'(step_sz) > delta) begin
            step_sz = delta[2:0];
        end
        next_lvl = (level_reg < tgt_reg) ? {1'b0, level_reg} + (PCT_W+1)'(step_sz)
                                         : {1'b0, level_reg} - (PCT_W+1)'(step_sz);
        next_clamped = (next_lvl > (PCT_W+1)'(MAX_PCT)) ? MAX_PCT : next_lvl[PCT_W-1:0];
        req_clamped  = (req_reg > REQ_W'(MAX_PCT)) ? MAX_PCT : req_reg[PCT_W-1:0];
    end

    assign duty_prod = (PCT_W+DUTY_MUL_W)'(level_reg) * (PCT_W+DUTY_MUL_W)'(DUTY_MUL);
    assign duty_raw  = duty_prod[DUTY_SHIFT +: DUTY_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= RST_LEVEL;
        end else if (cmd.apply) begin
            level_reg <= req_clamped;
        end else if (cmd.step && (tgt_reg != level_reg)) begin
            level_reg <= next_clamped;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            t_reg       <= t_next;
            req_reg     <= in_req;
            written_reg <= 1'b0;
        end
        if (cmd.apply) begin
            written_reg <= 1'b1;
        end
        if (cmd.step) begin
            written_reg <= tgt_reg != level_reg;
        end
        if (cmd.select) begin
            region_reg   <= region_next;
            off_reg      <= off_next;
            len_reg      <= len_next;
            span_abs_reg <= span_abs_next;
            span_neg_reg <= span[PCT_W];
            flat_reg     <= flat_next;
        end
        if (cmd.target) begin
            tgt_reg <= (region_reg == RG_FLAT) ? flat_reg : tgt9[PCT_W-1:0];
        end
        if (cmd.duty) begin
            duty_reg <= invert_reg ? ~duty_raw : duty_raw;
        end
        if (cmd.load_out) begin
            out_level_reg   <= level_reg;
            out_duty_reg    <= duty_reg;
            out_written_reg <= written_reg;
        end
    end

    assign m_tdata = {out_written_reg, out_duty_reg, out_level_reg};

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= MAX_PCT)
        else $error("level above full scale");

    a_div_idle_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_ramp_quotient: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.target && region_reg != RG_FLAT) |-> (div_quo[DIV_N_W-1:PCT_W] == '0))
        else $error("ramp quotient exceeds span");

endmodule

`default_nettype wire

### design/bsr_ctrl.sv
`default_nettype none

module bsr_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic                s_op,
    input  wire logic                s_time_valid,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output bsr_pkg::ctrl_cmd_t       cmd,
    input  wire bsr_pkg::dp_status_t sts
);
    import bsr_pkg::*;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_tready      = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    if (s_op) begin
                        state_next = ST_APPLY;
                    end else if (s_time_valid) begin
                        state_next = ST_SELECT;
                    end else begin
                        state_next = ST_DUTY;
                    end
                end
            end
            ST_SELECT: begin
                cmd.select = 1'b1;
                state_next = sts.need_div ? ST_DIV_START : ST_TARGET;
            end
            ST_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (!sts.div_busy) begin
                    state_next = ST_TARGET;
                end
            end
            ST_TARGET: begin
                cmd.target = 1'b1;
                state_next = ST_STEP;
            end
            ST_STEP: begin
                cmd.step   = 1'b1;
                state_next = ST_DUTY;
            end
            ST_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = ST_DUTY;
            end
            ST_DUTY: begin
                cmd.duty   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid_reg || m_tready))
        else $error("result overwritten before it was taken");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second beat accepted while an item is in work");

    a_load_then_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_tvalid_reg)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

### bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bsr_pkg::*;

    // input beat kinds, carried in s_tuser[0]
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_MANUAL = 1'b1;

    // the one register index the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    localparam int MIN_PER_DAY        = 1440;
    localparam int RANDOM_PHASES      = 12;
    localparam int RANDOM_PHASE_ITEMS = 90;
    // longer than a ramp tick takes, so this covers any straggler
    localparam int DRAIN_CYCLES       = 40;

    // one input beat, before packing
    typedef struct packed {
        logic              op;
        logic              time_ok;
        logic [HOUR_W-1:0] hour;
        logic [MOH_W-1:0]  minute;
        logic [REQ_W-1:0]  req;
    } panel_cmd_t;

    // one result beat, unpacked
    typedef struct packed {
        logic [PCT_W-1:0]  level;
        logic [DUTY_W-1:0] duty;
        logic              written;
    } panel_out_t;

    // register file contents
    typedef struct packed {
        logic [PCT_W-1:0] dim;
        logic [PCT_W-1:0] bright;
        logic [MIN_W-1:0] dawn_s;
        logic [MIN_W-1:0] dawn_e;
        logic [MIN_W-1:0] dusk_s;
        logic [MIN_W-1:0] dusk_e;
        logic             invert;
    } schedule_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;

    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    // shadow of the block: registers and the current level
    schedule_t  sched_model;
    int         level_model;
    // results still owed by the block, oldest first
    panel_out_t backlight_due[$];

    int mismatch_count = 0;
    int src_idle_pct   = 0;
    int snk_stall_pct  = 0;

    backlight_schedule_ramp uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // target level for minute of day t under the current schedule
    function automatic int schedule_target(int t);
        int dim;
        int bri;
        int span;
        int ds;
        int de;
        int ks;
        int ke;
        dim  = sched_model.dim;
        bri  = sched_model.bright;
        span = bri - dim;
        ds   = sched_model.dawn_s;
        de   = sched_model.dawn_e;
        ks   = sched_model.dusk_s;
        ke   = sched_model.dusk_e;
        // signed int division truncates toward zero, as the ramps need
        if (t >= ds && t < de && de > ds) begin
            return dim + (span * (t - ds)) / (de - ds);
        end
        if (t >= de && t < ks) begin
            return bri;
        end
        if (t >= ks && t < ke && ke > ks) begin
            return bri - (span * (t - ks)) / (ke - ks);
        end
        return dim;
    endfunction

    // one adaptive step from cur toward tgt, never overshooting
    function automatic int stepped_level(int cur, int tgt);
        int gap;
        int stride;
        if (cur == tgt) begin
            return cur;
        end
        gap = (cur > tgt) ? cur - tgt : tgt - cur;
        if (gap >= STEP_TH_BIG) begin
            stride = STEP_BIG;
        end else if (gap >= STEP_TH_MID) begin
            stride = STEP_MID;
        end else if (gap >= STEP_TH_SMALL) begin
            stride = STEP_SMALL;
        end else begin
            stride = STEP_MIN;
        end
        if (stride > gap) begin
            stride = gap;
        end
        return (cur < tgt) ? cur + stride : cur - stride;
    endfunction

    function automatic logic [DUTY_W-1:0] duty_for(int pct);
        int d;
        d = (pct * 255) / 100;
        return sched_model.invert ? DUTY_W'(255 - d) : DUTY_W'(d);
    endfunction

    // apply one accepted beat to the shadow and queue the result it owes
    function automatic void advance_backlight(panel_cmd_t c);
        panel_out_t r;
        int         tgt;
        int         nxt;
        r.written = 1'b0;
        if (c.op == OP_MANUAL) begin
            level_model = (c.req > MAX_PCT) ? int'(MAX_PCT) : int'(c.req);
            r.written   = 1'b1;
        end else if (c.time_ok) begin
            tgt = schedule_target(int'(c.hour) * 60 + int'(c.minute));
            nxt = stepped_level(level_model, tgt);
            // written follows the raw step, even when the clamp undoes it
            if (nxt != level_model) begin
                level_model = (nxt > MAX_PCT) ? int'(MAX_PCT) : nxt;
                r.written   = 1'b1;
            end
        end
        r.level = PCT_W'(level_model);
        r.duty  = duty_for(level_model);
        backlight_due.push_back(r);
    endfunction

    function automatic void shadow_reg_write(logic [CFG_IDX_W-1:0] idx,
                                             logic [CFG_DAT_W-1:0] data);
        case (idx)
            CFG_DIM:        sched_model.dim    = data[PCT_W-1:0];
            CFG_BRIGHT:     sched_model.bright = data[PCT_W-1:0];
            CFG_DAWN_START: sched_model.dawn_s = data;
            CFG_DAWN_END:   sched_model.dawn_e = data;
            CFG_DUSK_START: sched_model.dusk_s = data;
            CFG_DUSK_END:   sched_model.dusk_e = data;
            CFG_INVERT:     sched_model.invert = data[0];
            default:        ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // receiver stall pattern, redrawn every cycle
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // compare each result beat against the oldest owed result
    always @(posedge aclk) begin : result_check
        panel_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (backlight_due.size() == 0) begin
                report_mismatch("result beat with nothing owed", m_tdata, 0);
            end else begin
                want = backlight_due.pop_front();
                // m_tdata: [6:0] level, [14:7] duty, [15] duty_written
                if (m_tdata[6:0] !== want.level) begin
                    report_mismatch("level", m_tdata[6:0], want.level);
                end
                if (m_tdata[14:7] !== want.duty) begin
                    report_mismatch("duty", m_tdata[14:7], want.duty);
                end
                if (m_tdata[15] !== want.written) begin
                    report_mismatch("duty_written", m_tdata[15], want.written);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // send one input beat; s_tvalid is left high for a back-to-back follower
    task automatic send_beat(panel_cmd_t c);
        // random sender gaps
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        // s_tdata: [4:0] hour, [10:5] minute, [18:11] requested level, rest zero
        s_tdata  <= {5'b0, c.req, c.minute, c.hour};
        // s_tuser: [0] op, [1] time_valid
        s_tuser  <= {c.time_ok, c.op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        advance_backlight(c);
    endtask

    // stop sending and wait until every owed result has come back
    task automatic wait_backlight_idle();
        s_tvalid <= 1'b0;
        while (backlight_due.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // one register write beat; the caller drops cfg_valid after the last one
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        shadow_reg_write(idx, data);
    endtask

    // load a whole schedule while the block is idle
    task automatic set_config(schedule_t s);
        logic [CFG_DAT_W-PCT_W-1:0] pad_lvl;
        logic [CFG_DAT_W-2:0]       pad_bit;
        logic [CFG_DAT_W-1:0]       junk;
        wait_backlight_idle();
        // unused upper data bits carry junk that the block must drop
        pad_lvl = $urandom;
        write_reg(CFG_DIM, {pad_lvl, s.dim});
        pad_lvl = $urandom;
        write_reg(CFG_BRIGHT, {pad_lvl, s.bright});
        write_reg(CFG_DAWN_START, s.dawn_s);
        write_reg(CFG_DAWN_END, s.dawn_e);
        write_reg(CFG_DUSK_START, s.dusk_s);
        write_reg(CFG_DUSK_END, s.dusk_e);
        pad_bit = $urandom;
        write_reg(CFG_INVERT, {pad_bit, s.invert});
        // undecoded index, must change nothing
        junk = $urandom;
        write_reg(CFG_UNUSED, junk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic panel_cmd_t tick_at(int h, int m, logic ok);
        panel_cmd_t c;
        c.op      = OP_TICK;
        c.time_ok = ok;
        c.hour    = HOUR_W'(h);
        c.minute  = MOH_W'(m);
        c.req     = $urandom;   // ignored by a tick
        return c;
    endfunction

    function automatic panel_cmd_t manual_set(int req);
        panel_cmd_t c;
        c.op      = OP_MANUAL;
        c.time_ok = $urandom;   // don't care for a manual set
        c.hour    = $urandom;
        c.minute  = $urandom;
        c.req     = REQ_W'(req);
        return c;
    endfunction

    // mostly in range, sometimes above 100 up to the field limit
    function automatic logic [PCT_W-1:0] random_pct();
        if ($urandom_range(99) < 15) begin
            return PCT_W'($urandom_range(101, 127));
        end
        return PCT_W'($urandom_range(0, 100));
    endfunction

    function automatic logic [MIN_W-1:0] clip_minute(int m);
        return MIN_W'((m > MIN_PER_DAY - 1) ? MIN_PER_DAY - 1 : m);
    endfunction

    // schedule for random phase n: the first five are corner settings
    function automatic schedule_t pick_schedule(int n);
        schedule_t s;
        s.dim    = random_pct();
        s.bright = random_pct();
        s.dawn_s = $urandom_range(0, 1200);
        s.dawn_e = clip_minute(s.dawn_s + $urandom_range(0, 200));
        s.dusk_s = clip_minute(s.dawn_e + $urandom_range(0, 600));
        s.dusk_e = clip_minute(s.dusk_s + $urandom_range(0, 200));
        s.invert = $urandom;
        // now and then an arbitrary, possibly unordered, set of edges
        if ($urandom_range(99) < 15) begin
            s.dawn_e = $urandom_range(0, MIN_PER_DAY - 1);
            s.dusk_e = $urandom_range(0, MIN_PER_DAY - 1);
        end
        case (n)
            0: begin
                // reset values
                s = '{RST_DIM, RST_BRIGHT, RST_DAWN_START, RST_DAWN_END,
                      RST_DUSK_START, RST_DUSK_END, 1'b0};
            end
            1: begin
                // dawn ramp across the whole day, widest range
                s = '{7'd0, 7'd100, 11'd0, 11'd1439, 11'd1439, 11'd1439, 1'b0};
            end
            2: begin
                // falling dawn, rising dusk, inverted duty
                s.dim    = 7'd100;
                s.bright = 7'd0;
                s.invert = 1'b1;
            end
            3: begin
                // both ends above 100, level pinned by the clamp
                s.dim    = 7'd127;
                s.bright = 7'd101;
            end
            4: begin
                // ramps that never open
                s.dawn_e = s.dawn_s;
                s.dusk_e = MIN_W'($urandom_range(0, s.dusk_s));
            end
            default: ;
        endcase
        return s;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset schedule: dim 0, bright 100, dawn 6:00-7:00, dusk 20:00-21:00
    task automatic test_reset_defaults();
        send_beat(tick_at(12, 0, 1'b0));   // invalid tick, duty of kept level
        send_beat(tick_at(12, 0, 1'b1));   // midday, already at target
        send_beat(tick_at(0, 0, 1'b1));    // night, big step down
        send_beat(manual_set(255));        // clamp from the top of the field
        send_beat(manual_set(0));
        send_beat(tick_at(6, 0, 1'b1));    // dawn start, target still dim
        send_beat(tick_at(6, 59, 1'b1));   // last dawn minute
        send_beat(tick_at(7, 0, 1'b1));    // dawn end, day level
        send_beat(tick_at(20, 0, 1'b1));   // dusk start
        send_beat(tick_at(20, 30, 1'b1));  // mid dusk
        send_beat(tick_at(21, 0, 1'b1));   // dusk end
        send_beat(tick_at(31, 63, 1'b1));  // time beyond the day
        // each step size in turn, from just below the day level
        send_beat(manual_set(98));
        send_beat(tick_at(12, 0, 1'b1));
        send_beat(manual_set(97));
        send_beat(tick_at(12, 0, 1'b1));
        send_beat(manual_set(89));
        send_beat(tick_at(12, 0, 1'b1));
        send_beat(manual_set(80));
        send_beat(tick_at(12, 0, 1'b1));
    endtask

    // targets above 100: the step is taken, then clamped back
    task automatic test_levels_over_range();
        set_config('{7'd120, 7'd127, RST_DAWN_START, RST_DAWN_END,
                     RST_DUSK_START, RST_DUSK_END, 1'b0});
        send_beat(manual_set(100));
        send_beat(tick_at(12, 0, 1'b1));
        send_beat(tick_at(0, 0, 1'b1));
    endtask

    // empty dawn and backwards dusk, inverted duty
    task automatic test_empty_ramps();
        set_config('{7'd10, 7'd90, 11'd500, 11'd500, 11'd900, 11'd800, 1'b1});
        send_beat(tick_at(8, 20, 1'b1));   // on the empty dawn edge
        send_beat(tick_at(14, 0, 1'b1));   // day
        send_beat(tick_at(15, 10, 1'b1));  // past the dead dusk ramp
    endtask

    // runs of consecutive ticks near the ramp edges, with noise mixed in
    task automatic run_random_phase(int n_items);
        panel_cmd_t c;
        int         sent;
        int         t;
        int         run_len;
        int         anchor;
        int         r;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(4))
                0:       anchor = sched_model.dawn_s;
                1:       anchor = sched_model.dawn_e;
                2:       anchor = sched_model.dusk_s;
                3:       anchor = sched_model.dusk_e;
                default: anchor = $urandom_range(0, MIN_PER_DAY - 1);
            endcase
            t       = (anchor + MIN_PER_DAY + $urandom_range(0, 80) - 40) % MIN_PER_DAY;
            run_len = $urandom_range(4, 24);
            repeat (run_len) begin
                r = $urandom_range(99);
                if (r < 8) begin
                    c = manual_set((r < 4) ? $urandom_range(0, 100) : $urandom_range(0, 255));
                end else if (r < 13) begin
                    c = tick_at($urandom_range(0, 31), $urandom_range(0, 63), 1'b0);
                end else if (r < 17) begin
                    c = tick_at($urandom_range(0, 31), $urandom_range(0, 63), 1'b1);
                end else begin
                    c = tick_at(t / 60, t % 60, 1'b1);
                    t = (t + $urandom_range(0, 3)) % MIN_PER_DAY;
                end
                send_beat(c);
                sent++;
            end
        end
    endtask

    // several schedules, cycling through four idle and stall patterns
    task automatic test_random_schedules();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p % 4)
                0: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1: begin
                    src_idle_pct  = 86;
                    snk_stall_pct = 0;
                end
                2: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 86;
                end
                default: begin
                    src_idle_pct  = 24;
                    snk_stall_pct = 24;
                end
            endcase
            // set_config drains first, so the sender also pauses here
            set_config(pick_schedule(p));
            run_random_phase(RANDOM_PHASE_ITEMS);
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        sched_model = '{RST_DIM, RST_BRIGHT, RST_DAWN_START, RST_DAWN_END,
                        RST_DUSK_START, RST_DUSK_END, 1'b0};
        level_model = RST_LEVEL;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_levels_over_range();
        test_empty_ramps();
        test_random_schedules();

        wait_backlight_idle();
        // any beat arriving now is a stray result
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog, well above the slowest legal run
    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
